/* hw/rtl/request_tag_remap_router_defines.svh */
// Assertion macros for the request tag remap router.
// Used by request_tag_remap_router.sv; expects clk and rst in scope.
`ifndef REQUEST_TAG_REMAP_ROUTER_DEFINES_SVH
`define REQUEST_TAG_REMAP_ROUTER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define RTRR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RTRR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/rtrr_pkg.sv */
// Package for the request tag remap router: sizes, codes and word types.
// No dependencies.
package rtrr_pkg;

  localparam int SLOTS        = 64;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int PTR_W        = SLOT_W + 1;
  localparam int ID_W         = 64;
  localparam int DOM_W        = 16;
  localparam int DOMAIN_SHIFT = 16;
  localparam int CFG_AW       = 4;
  localparam int CFG_DW       = 32;

  localparam logic KIND_REQ = 1'b0;
  localparam logic KIND_RSP = 1'b1;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  localparam logic [1:0] REG_INTERCEPT_FRONT = 2'd0;
  localparam logic [1:0] REG_COPY_FRONT      = 2'd1;
  localparam logic [1:0] REG_INTERCEPT_BACK  = 2'd2;
  localparam logic [1:0] REG_COPY_BACK       = 2'd3;

  typedef struct packed {
    logic             kind;
    logic [ID_W-1:0]  item_id;
    logic [DOM_W-1:0] source_domain;
    logic             is_probe;
  } item_t;

  typedef struct packed {
    logic             status;
    logic [ID_W-1:0]  result_id;
    logic [DOM_W-1:0] result_domain;
    logic             to_backend;
    logic             to_user;
    logic             to_frontend;
    logic             add_cookie;
  } result_t;

endpackage

/* hw/rtl/request_tag_remap_router.sv */
// Request tag remap router: free-list tag allocator with mode-based routing.
// Depends on rtrr_pkg and request_tag_remap_router_defines.svh.
//
//   channel   dir  handshake                  word
//   item      in   item_valid/item_ready      rtrr_pkg::item_t
//   result    out  result_valid/result_ready  rtrr_pkg::result_t
//   config    in   APB psel/penable/pwrite    1-bit mode registers at 4*i
//
// One word per cycle sustained while the result is not stalled; each word
// sits in the input register, where the slot memories (read at acceptance)
// are used, then moves to the result register.
// Reset is synchronous; the free list reads as entry i = i until written,
// through per-entry valid bits, so no clearing pass is needed.
// A stalled result holds one word in the input register and drops item_ready.
`include "request_tag_remap_router_defines.svh"

module request_tag_remap_router (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  rtrr_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output rtrr_pkg::result_t              result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rtrr_pkg::CFG_AW-1:0]    paddr,
  input  logic [rtrr_pkg::CFG_DW-1:0]    pwdata,
  output logic [rtrr_pkg::CFG_DW-1:0]    prdata,
  output logic                           pready
);
  import rtrr_pkg::*;

  logic              intercept_front;
  logic              copy_front;
  logic              intercept_back;
  logic              copy_back;
  logic              cfg_write;
  logic [1:0]        cfg_index;
  logic              cfg_bit;

  logic              s1_valid;
  item_t             s1_item;
  logic              accept;
  logic              advance;

  logic [PTR_W-1:0]  take_pointer;
  logic [PTR_W-1:0]  give_pointer;
  logic [PTR_W-1:0]  take_pointer_next;
  logic [PTR_W-1:0]  give_pointer_next;
  logic [PTR_W-1:0]  free_cnt;

  logic [SLOT_W-1:0] ring_mem [SLOTS];
  logic [SLOTS-1:0]  ring_vld;
  logic [SLOT_W-1:0] ring_rd_data;
  logic [SLOT_W-1:0] ring_rd_addr;
  logic              ring_rd_vld;
  logic              ring_byp;
  logic [SLOT_W-1:0] ring_byp_data;

  logic [ID_W-1:0]   saved_id_mem  [SLOTS];
  logic [DOM_W-1:0]  saved_dom_mem [SLOTS];
  logic [ID_W-1:0]   saved_rd_id;
  logic [DOM_W-1:0]  saved_rd_dom;
  logic              saved_byp;
  logic [ID_W-1:0]   saved_byp_id;
  logic [DOM_W-1:0]  saved_byp_dom;

  logic              is_req;
  logic              grant;
  logic              fwd_front;
  logic              do_free;
  logic              take_inc;
  logic              give_inc;
  logic [SLOT_W-1:0] req_slot;
  logic [SLOT_W-1:0] rsp_slot;
  logic [SLOT_W-1:0] ring_rd_addr_next;
  logic [SLOT_W-1:0] saved_rd_addr_next;
  logic [ID_W-1:0]   rsp_id;
  logic [DOM_W-1:0]  rsp_dom;
  result_t           result_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[CFG_AW-1:2];
  assign cfg_bit   = pwdata[0];

  always_comb begin
    prdata = '0;
    case (cfg_index)
      REG_INTERCEPT_FRONT: prdata[0] = intercept_front;
      REG_COPY_FRONT:      prdata[0] = copy_front;
      REG_INTERCEPT_BACK:  prdata[0] = intercept_back;
      REG_COPY_BACK:       prdata[0] = copy_back;
      default:             prdata    = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      intercept_front <= 1'b0;
      copy_front      <= 1'b0;
      intercept_back  <= 1'b0;
      copy_back       <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_INTERCEPT_FRONT: intercept_front <= cfg_bit;
        REG_COPY_FRONT:      copy_front      <= cfg_bit;
        REG_INTERCEPT_BACK:  intercept_back  <= cfg_bit;
        REG_COPY_BACK:       copy_back       <= cfg_bit;
        default: ;
      endcase
    end
  end

  assign advance    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || advance;
  assign accept     = item_valid && item_ready;

  assign free_cnt  = give_pointer - take_pointer;
  assign is_req    = (s1_item.kind == KIND_REQ);
  assign grant     = is_req && (free_cnt != '0);
  assign fwd_front = !(intercept_back || intercept_front);
  assign do_free   = !is_req && fwd_front && !free_cnt[PTR_W-1];
  assign take_inc  = advance && grant;
  assign give_inc  = advance && do_free;

  assign take_pointer_next = take_pointer + PTR_W'(take_inc);
  assign give_pointer_next = give_pointer + PTR_W'(give_inc);

  assign req_slot = ring_byp ? ring_byp_data : (ring_rd_vld ? ring_rd_data : ring_rd_addr);
  assign rsp_slot = s1_item.item_id[SLOT_W-1:0];
  assign rsp_id   = saved_byp ? saved_byp_id  : saved_rd_id;
  assign rsp_dom  = saved_byp ? saved_byp_dom : saved_rd_dom;

  assign ring_rd_addr_next  = take_pointer_next[SLOT_W-1:0];
  assign saved_rd_addr_next = item.item_id[SLOT_W-1:0];

  always_comb begin
    result_next = '0;
    if (is_req) begin
      if (!grant) begin
        result_next.status = STATUS_REFUSED;
      end else begin
        result_next.status        = STATUS_DONE;
        result_next.result_id     = (ID_W'(s1_item.source_domain) << DOMAIN_SHIFT)
                                    | ID_W'(req_slot);
        result_next.result_domain = s1_item.source_domain;
        result_next.to_backend    = !(intercept_front || intercept_back);
        result_next.to_user       = intercept_front || copy_front;
        result_next.add_cookie    = s1_item.is_probe;
      end
    end else begin
      result_next.status        = STATUS_DONE;
      result_next.result_id     = rsp_id;
      result_next.result_domain = rsp_dom;
      result_next.to_user       = intercept_back || copy_back;
      result_next.to_frontend   = fwd_front;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      take_pointer <= '0;
      give_pointer <= PTR_W'(SLOTS);
      ring_vld     <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      take_pointer <= take_pointer_next;
      give_pointer <= give_pointer_next;
      if (give_inc) begin
        ring_vld[give_pointer[SLOT_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (give_inc) begin
      ring_mem[give_pointer[SLOT_W-1:0]] <= rsp_slot;
    end
    if (accept) begin
      ring_rd_data  <= ring_mem[ring_rd_addr_next];
      ring_rd_addr  <= ring_rd_addr_next;
      ring_rd_vld   <= ring_vld[ring_rd_addr_next];
      ring_byp      <= give_inc && (give_pointer[SLOT_W-1:0] == ring_rd_addr_next);
      ring_byp_data <= rsp_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (take_inc) begin
      saved_id_mem[req_slot]  <= s1_item.item_id;
      saved_dom_mem[req_slot] <= s1_item.source_domain;
    end
    if (accept) begin
      saved_rd_id   <= saved_id_mem[saved_rd_addr_next];
      saved_rd_dom  <= saved_dom_mem[saved_rd_addr_next];
      saved_byp     <= take_inc && (req_slot == saved_rd_addr_next);
      saved_byp_id  <= s1_item.item_id;
      saved_byp_dom <= s1_item.source_domain;
    end
  end

  `RTRR_ASSERT(a_free_cnt_bound, (free_cnt <= PTR_W'(SLOTS)),
    "free count above slot total")
  `RTRR_ASSERT(a_refused_no_take,
    (advance && is_req && !grant) |=> $stable(take_pointer),
    "refused request moved take pointer")
  `RTRR_ASSERT(a_refused_clean,
    (result_valid && result.status == STATUS_REFUSED) |->
      (result.result_id == '0 && !result.to_backend && !result.to_user),
    "refused word carries data")
  `RTRR_ASSERT_ALWAYS(a_ready_stall, (!item_ready) |-> s1_valid,
    "item_ready low with empty input register")

endmodule
